// ===== hw/rtl/pfve_pkg.sv =====
// Package with phase codes, widths and constants of the feature value extractor.
package pfve_pkg;
    localparam int MaxMessageBytes = 65536;
    localparam int PosW = $clog2(MaxMessageBytes + 1);

    typedef enum logic [3:0] {
        PH_OTAG, PH_OSKIPVAR, PH_OLEN, PH_OSKIPFIX, PH_OSKIPTO, PH_ITAG,
        PH_ISKIPVAR, PH_ILENVAL, PH_ILENOTHER, PH_ISKIPFIX, PH_ISKIPTO,
        PH_FLOAT, PH_INT, PH_HALT
    } t_phase;

    typedef logic [PosW-1:0] t_pos;

    typedef struct packed {
        logic        has_value;
        logic        value_is_integer;
        logic [63:0] value;
        logic        message_end;
        logic        stopped_early;
    } t_result;
endpackage

// ===== hw/rtl/protobuf_feature_value_extractor.sv =====
// Top level of the feature value extractor: input register, parser and output register.
// One message byte is accepted per cycle; each byte passes an input register, combinational
// decode logic and an output register, and its result is offered on the master side from the
// output register. Throughput is one byte per cycle; a stalled result holds the parser, and
// the input stalls only when both registers are full.
module protobuf_feature_value_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] message_length
    input  logic        s_axis_tuser,  // [0] start_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [63:0] value
    output logic [2:0]  m_axis_tuser,  // [0] has_value, [1] value_is_integer, [2] stopped_early
    output logic        m_axis_tlast   // message_end
);
    import pfve_pkg::*;

    logic        r_in_vld, r_out_vld, p_vld, adv;
    logic [23:0] r_data;
    logic        r_start;
    t_result     p_res, r_res;

    // The parser advances when the output register can take its result.
    assign adv = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (adv) r_out_vld <= r_in_vld && p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_data <= s_axis_tdata;
            r_start <= s_axis_tuser;
        end
        if (adv) r_res <= p_res;
    end

    pfve_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld && adv),
        .i_byte  (r_data[7:0]),
        .i_start (r_start),
        .i_len   (r_data[23:8]),
        .o_valid (p_vld),
        .o_result(p_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_res.value;
    assign m_axis_tuser  = {r_res.stopped_early, r_res.value_is_integer, r_res.has_value};
    assign m_axis_tlast  = r_res.message_end;
endmodule

// ===== hw/rtl/pfve_parser.sv =====
// Parser state and per-byte decode logic of the feature value extractor.
module pfve_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    input  logic [15:0]          i_len,
    output logic                 o_valid,
    output pfve_pkg::t_result    o_result
);
    import pfve_pkg::*;

    t_pos        r_bpos, n_bpos, r_mend, n_mend, r_oend, n_oend, r_iend, n_iend;
    t_phase      r_ph, n_ph;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_vcnt, n_vcnt, r_skip, n_skip;
    logic [1:0]  r_kind, n_kind, r_fcnt, n_fcnt;
    logic [31:0] r_flt, n_flt;
    logic        r_halt, n_halt;

    always_comb begin
        t_pos        bpos, mend, pos, bound, room;
        t_phase      ph;
        logic [63:0] acc, tag;
        logic [3:0]  vcnt;
        logic [1:0]  kind;
        logic [31:0] flt;
        logic [1:0]  fcnt;
        logic        halt, inner, done, over, emit, isint, last;
        logic [63:0] val;
        logic [6:0]  sh;
        logic [3:0]  nfix;
        logic [2:0]  wt;
        bpos = r_bpos; mend = r_mend; ph = r_ph; acc = r_acc; vcnt = r_vcnt;
        kind = r_kind; flt = r_flt; fcnt = r_fcnt; halt = r_halt;
        n_oend = r_oend; n_iend = r_iend; n_skip = r_skip;
        emit = 1'b0; isint = 1'b0; last = 1'b0; val = '0; o_valid = 1'b0;
        pos = '0; room = '0; bound = '0; tag = '0; wt = '0; inner = 1'b0;
        nfix = '0; sh = '0; done = 1'b0; over = 1'b0;
        if (i_start) begin
            bpos = '0; n_oend = '0; kind = '0; n_iend = '0; n_skip = '0; halt = 1'b0;
            ph = PH_OTAG; acc = '0; vcnt = '0; flt = '0; fcnt = '0;
            mend = t_pos'(i_len);
        end
        if (i_valid && bpos < mend) begin
            pos = bpos + t_pos'(1);
            bpos = pos;
            // Varint step on the current accumulator.
            sh = 7'(vcnt) * 7'd7;
            if (sh < 7'd64)
                acc = acc | (64'(i_byte[6:0]) << sh[5:0]);
            done = !i_byte[7];
            over = i_byte[7] && (vcnt == 4'd9);
            inner = (ph == PH_ITAG);
            bound = inner ? n_oend : mend;
            tag = acc;
            wt = tag[2:0];
            nfix = (wt == 3'd1) ? 4'd8 : 4'd4;
            case (ph)
                PH_OTAG, PH_ITAG, PH_OSKIPVAR, PH_ISKIPVAR, PH_OLEN, PH_ILENVAL,
                PH_ILENOTHER, PH_INT: begin
                    if (!done) vcnt = vcnt + 4'd1;
                end
                default: ;
            endcase
            case (ph)
                PH_OTAG, PH_ITAG: begin
                    if (over) begin
                        if (inner) ph = PH_OSKIPTO;
                        else begin halt = 1'b1; ph = PH_HALT; end
                        acc = '0; vcnt = '0;
                    end else if (done) begin
                        acc = '0; vcnt = '0;
                        if (wt == 3'd0) ph = inner ? PH_ISKIPVAR : PH_OSKIPVAR;
                        else if (wt == 3'd1 || wt == 3'd5) begin
                            if ((PosW+1)'(pos) + (PosW+1)'(nfix) > (PosW+1)'(bound))
                                ph = inner ? PH_ITAG : PH_OTAG;
                            else begin
                                ph = inner ? PH_ISKIPFIX : PH_OSKIPFIX;
                                n_skip = nfix;
                            end
                        end else if (wt == 3'd2) begin
                            if (inner) ph = (tag[63:3] == 61'd1) ? PH_ILENVAL : PH_ILENOTHER;
                            else begin
                                kind = (tag[63:3] == 61'd2) ? 2'd1 :
                                       (tag[63:3] == 61'd3) ? 2'd2 : 2'd0;
                                ph = PH_OLEN;
                            end
                        end else ph = inner ? PH_ITAG : PH_OTAG;
                    end
                end
                PH_OSKIPVAR, PH_ISKIPVAR: begin
                    if (done || over) begin
                        ph = (ph == PH_OSKIPVAR) ? PH_OTAG : PH_ITAG;
                        acc = '0; vcnt = '0;
                    end
                end
                PH_OLEN: begin
                    room = mend - pos;
                    if (over || (done && acc > 64'(room))) begin
                        halt = 1'b1; ph = PH_HALT; acc = '0; vcnt = '0;
                    end else if (done) begin
                        n_oend = pos + t_pos'(acc);
                        ph = (kind != 2'd0) ? PH_ITAG : PH_OSKIPTO;
                        acc = '0; vcnt = '0;
                    end
                end
                PH_OSKIPFIX, PH_ISKIPFIX: begin
                    if (n_skip > 4'd0) n_skip = n_skip - 4'd1;
                    if (n_skip == 4'd0) begin
                        ph = (ph == PH_OSKIPFIX) ? PH_OTAG : PH_ITAG;
                        acc = '0; vcnt = '0;
                    end
                end
                PH_ILENVAL, PH_ILENOTHER: begin
                    room = (pos <= n_oend) ? n_oend - pos : '0;
                    if (over) begin
                        ph = PH_OSKIPTO; acc = '0; vcnt = '0;
                    end else if (done) begin
                        n_iend = (acc > 64'(room)) ? n_oend : pos + t_pos'(acc);
                        if (ph == PH_ILENVAL) ph = (kind == 2'd1) ? PH_FLOAT : PH_INT;
                        else ph = PH_ISKIPTO;
                        acc = '0; vcnt = '0;
                    end
                end
                PH_FLOAT: begin
                    flt = flt | (32'(i_byte) << {fcnt, 3'b000});
                    if (fcnt == 2'd3) begin
                        emit = 1'b1; val = 64'(flt); flt = '0; fcnt = '0;
                    end else fcnt = fcnt + 2'd1;
                end
                PH_INT: begin
                    if (done) begin
                        emit = 1'b1; isint = 1'b1; val = acc; acc = '0; vcnt = '0;
                    end else if (over) begin
                        ph = PH_ISKIPTO; acc = '0; vcnt = '0;
                    end
                end
                default: ;
            endcase
            if ((ph == PH_FLOAT || ph == PH_INT || ph == PH_ISKIPTO) && pos >= n_iend) begin
                ph = PH_ITAG; acc = '0; vcnt = '0; flt = '0; fcnt = '0;
            end
            if (ph >= PH_ITAG && ph <= PH_INT && pos >= n_oend) begin
                ph = PH_OTAG; acc = '0; vcnt = '0; flt = '0; fcnt = '0;
            end
            if (ph == PH_OSKIPTO && pos >= n_oend) begin
                ph = PH_OTAG; acc = '0; vcnt = '0; flt = '0; fcnt = '0;
            end
            if (pos >= mend) begin
                last = 1'b1;
                if ((ph == PH_OTAG && vcnt != 4'd0) || ph == PH_OLEN) halt = 1'b1;
            end
            o_valid = emit || last;
        end
        n_bpos = bpos; n_mend = mend; n_ph = ph; n_acc = acc; n_vcnt = vcnt;
        n_kind = kind; n_flt = flt; n_fcnt = fcnt; n_halt = halt;
        o_result.has_value = emit;
        o_result.value_is_integer = isint;
        o_result.value = val;
        o_result.message_end = last;
        o_result.stopped_early = last && halt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0; r_mend <= '0; r_ph <= PH_OTAG; r_acc <= '0; r_vcnt <= '0;
            r_oend <= '0; r_kind <= '0; r_iend <= '0; r_skip <= '0; r_flt <= '0;
            r_fcnt <= '0; r_halt <= 1'b0;
        end else if (i_valid) begin
            r_bpos <= n_bpos; r_mend <= n_mend; r_ph <= n_ph; r_acc <= n_acc;
            r_vcnt <= n_vcnt; r_oend <= n_oend; r_kind <= n_kind; r_iend <= n_iend;
            r_skip <= n_skip; r_flt <= n_flt; r_fcnt <= n_fcnt; r_halt <= n_halt;
        end
    end
endmodule

// ===== hw/rtl/pfve_checker.sv =====
// Port-level assertions for the feature value extractor and their bind.
module pfve_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tlast, m_axis_tuser, m_axis_tdata}))
        else $error("result changed while stalled");
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
        else $error("empty result word");
    a_stop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
        else $error("stopped_early without message_end");
    a_float_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("float result with upper bits set");
    a_int_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tdata == 64'd0)
        else $error("value without has_value");
endmodule

bind protobuf_feature_value_extractor pfve_checker u_pfve_checker (.*);

// ===== tb/protobuf_feature_value_extractor_test.sv =====
// Testbench for the feature value extractor: directed and random messages against a predictor.
module protobuf_feature_value_extractor_test;
    import pfve_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] data_byte, [23:8] message_length
    logic        s_axis_tuser = 1'b0; // [0] start_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [63:0] value
    logic [2:0]  m_axis_tuser;        // [0] has_value, [1] value_is_integer, [2] stopped_early
    logic        m_axis_tlast;

    protobuf_feature_value_extractor DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_result     pending_results[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;

    // Parser state of the predictor.
    int unsigned pos_now, msg_end, outer_end, inner_end, skip_left, flt_cnt, vint_cnt;
    logic [31:0] flt_acc;
    logic [63:0] vint_acc;
    logic [1:0]  field_kind;
    logic        halted;
    t_phase      phase;

    function automatic void enter(t_phase p);
        phase = p;
        vint_acc = '0;
        vint_cnt = 0;
        flt_acc = '0;
        flt_cnt = 0;
    endfunction

    function automatic int feed_varint(logic [7:0] b);
        int unsigned sh;
        sh = 7 * vint_cnt;
        if (sh < 64) vint_acc |= {57'd0, b[6:0]} << sh;
        if (!b[7]) return 1;
        vint_cnt++;
        if (vint_cnt >= 10) return 2;
        return 0;
    endfunction

    function automatic void clear_parser();
        pos_now = 0;
        msg_end = 0;
        outer_end = 0;
        field_kind = 0;
        inner_end = 0;
        skip_left = 0;
        halted = 0;
        enter(PH_OTAG);
    endfunction

    function automatic void stop_outer();
        halted = 1;
        enter(PH_HALT);
    endfunction

    function automatic void decode_tag(logic [63:0] tag, int unsigned pos, int unsigned bound,
                                       bit inner);
        logic [2:0]  wt;
        logic [60:0] fn;
        int unsigned n;
        wt = tag[2:0];
        fn = tag[63:3];
        if (wt == 0) begin
            enter(inner ? PH_ISKIPVAR : PH_OSKIPVAR);
        end else if (wt == 1 || wt == 5) begin
            n = (wt == 1) ? 8 : 4;
            if (pos + n > bound) begin
                enter(inner ? PH_ITAG : PH_OTAG);
            end else begin
                enter(inner ? PH_ISKIPFIX : PH_OSKIPFIX);
                skip_left = n;
            end
        end else if (wt == 2) begin
            if (inner) begin
                enter(fn == 1 ? PH_ILENVAL : PH_ILENOTHER);
            end else begin
                field_kind = (fn == 2) ? 2'd1 : ((fn == 3) ? 2'd2 : 2'd0);
                enter(PH_OLEN);
            end
        end else begin
            enter(inner ? PH_ITAG : PH_OTAG);
        end
    endfunction

    function automatic bit predict_byte(logic [7:0] b, logic start, logic [15:0] len,
                                        output t_result res);
        bit          emit, is_int, last;
        logic [63:0] val;
        int unsigned pos, room;
        int          r;
        emit = 0;
        is_int = 0;
        last = 0;
        val = '0;
        res = '0;
        if (start) begin
            clear_parser();
            msg_end = (len > MaxMessageBytes) ? MaxMessageBytes : len;
        end
        if (pos_now >= msg_end) return 0;
        pos = pos_now + 1;
        pos_now = pos;
        case (phase)
            PH_OTAG: begin
                r = feed_varint(b);
                if (r == 2) stop_outer();
                else if (r == 1) decode_tag(vint_acc, pos, msg_end, 0);
            end
            PH_OSKIPVAR: begin
                if (feed_varint(b) != 0) enter(PH_OTAG);
            end
            PH_OLEN: begin
                r = feed_varint(b);
                if (r == 2) begin
                    stop_outer();
                end else if (r == 1) begin
                    room = (pos <= msg_end) ? msg_end - pos : 0;
                    if (vint_acc > 64'(room)) begin
                        stop_outer();
                    end else begin
                        outer_end = pos + vint_acc[31:0];
                        enter(field_kind != 0 ? PH_ITAG : PH_OSKIPTO);
                    end
                end
            end
            PH_OSKIPFIX, PH_ISKIPFIX: begin
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) enter(phase == PH_OSKIPFIX ? PH_OTAG : PH_ITAG);
            end
            PH_ITAG: begin
                r = feed_varint(b);
                if (r == 2) enter(PH_OSKIPTO);
                else if (r == 1) decode_tag(vint_acc, pos, outer_end, 1);
            end
            PH_ISKIPVAR: begin
                if (feed_varint(b) != 0) enter(PH_ITAG);
            end
            PH_ILENVAL, PH_ILENOTHER: begin
                r = feed_varint(b);
                if (r == 2) begin
                    enter(PH_OSKIPTO);
                end else if (r == 1) begin
                    room = (pos <= outer_end) ? outer_end - pos : 0;
                    inner_end = (vint_acc > 64'(room)) ? outer_end : pos + vint_acc[31:0];
                    if (phase == PH_ILENVAL) enter(field_kind == 1 ? PH_FLOAT : PH_INT);
                    else enter(PH_ISKIPTO);
                end
            end
            PH_FLOAT: begin
                flt_acc |= {24'd0, b} << (8 * (flt_cnt & 3));
                if (flt_cnt >= 3) begin
                    emit = 1;
                    val = {32'd0, flt_acc};
                    flt_acc = '0;
                    flt_cnt = 0;
                end else begin
                    flt_cnt++;
                end
            end
            PH_INT: begin
                r = feed_varint(b);
                if (r == 1) begin
                    emit = 1;
                    is_int = 1;
                    val = vint_acc;
                    vint_acc = '0;
                    vint_cnt = 0;
                end else if (r == 2) begin
                    enter(PH_ISKIPTO);
                end
            end
            default: ;
        endcase
        if ((phase == PH_FLOAT || phase == PH_INT || phase == PH_ISKIPTO) && pos >= inner_end)
            enter(PH_ITAG);
        if (phase >= PH_ITAG && phase <= PH_INT && pos >= outer_end) enter(PH_OTAG);
        if (phase == PH_OSKIPTO && pos >= outer_end) enter(PH_OTAG);
        if (pos >= msg_end) begin
            last = 1;
            if ((phase == PH_OTAG && vint_cnt > 0) || phase == PH_OLEN) halted = 1;
        end
        if (!emit && !last) return 0;
        res.has_value = emit;
        res.value_is_integer = emit && is_int;
        res.value = emit ? val : '0;
        res.message_end = last;
        res.stopped_early = last && halted;
        return 1;
    endfunction

    task automatic send_byte(logic [7:0] b, logic start, logic [15:0] len);
        t_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {len, b};
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_byte(b, start, len, res))
            pending_results.insert(pending_results.size(), res);
        bytes_sent++;
    endtask

    task automatic send_message(logic [7:0] q[$], int len);
        foreach (q[i]) send_byte(q[i], i == 0, i == 0 ? 16'(len) : 16'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic void put_varint(ref logic [7:0] q[$], input logic [63:0] v);
        do begin
            q.insert(q.size(), {v > 64'h7F, v[6:0]});
            v = v >> 7;
        end while (v != 0);
    endfunction

    function automatic logic [63:0] rand_int64();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic void add_list(ref logic [7:0] q[$], input bit is_float);
        logic [7:0] p[$];
        logic [7:0] vals[$];
        int         k;
        k = $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0) begin
            p.insert(p.size(), 8'h10);
            put_varint(p, rand_int64());
        end
        if (is_float) begin
            repeat (4 * k + ($urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0))
                vals.insert(vals.size(), 8'($urandom));
        end else begin
            repeat (k) put_varint(vals, rand_int64());
        end
        p.insert(p.size(), 8'h0A);
        put_varint(p, 64'(vals.size()));
        p = {p, vals};
        q.insert(q.size(), is_float ? 8'h12 : 8'h1A);
        put_varint(q, 64'(p.size()));
        q = {q, p};
    endfunction

    task automatic send_random_message();
        logic [7:0] q[$];
        int         len, r;
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                add_list(q, 1);
            end else if (r < 7) begin
                add_list(q, 0);
            end else if (r == 7) begin
                q.insert(q.size(), 8'h08);
                put_varint(q, rand_int64());
            end else if (r == 8) begin
                q.insert(q.size(), $urandom_range(0, 1) ? 8'h09 : 8'h0D);
                repeat (q[$] == 8'h09 ? 8 : 4) q.insert(q.size(), 8'($urandom));
            end else begin
                q.insert(q.size(), 8'h22);
                q.insert(q.size(), 8'd2);
                q.insert(q.size(), 8'($urandom));
                q.insert(q.size(), 8'($urandom));
            end
        end
        len = q.size();
        r = $urandom_range(0, 9);
        if (r == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        else if (r == 1) len = $urandom_range(1, q.size());
        else if (r == 2) begin
            q.delete();
            repeat ($urandom_range(1, 16)) q.insert(q.size(), 8'($urandom));
            len = q.size();
        end
        send_message(q, len);
    endtask

    task automatic test_directed();
        logic [7:0] q[$];
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'h12, 1'b1, 16'd0);
        q = '{8'h12, 8'h07, 8'h0A, 8'h05, 8'h00, 8'h00, 8'h80, 8'h3F, 8'h55};
        send_message(q, q.size());
        q = '{8'h1A, 8'h0C, 8'h0A, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'hFF, 8'h01};
        send_message(q, q.size());
        q = '{8'h1A, 8'h0D, 8'h0A, 8'h0B, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
              8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
        send_message(q, q.size());
        q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
        send_message(q, q.size());
        q = '{8'h0B, 8'h0F, 8'h09, 8'h01, 8'h12, 8'h7F, 8'h00};
        send_message(q, q.size());
        q = '{8'h12, 8'h05, 8'h0A, 8'h7F, 8'h01, 8'h02, 8'h03};
        send_message(q, q.size());
        q = '{8'h08, 8'h80};
        send_message(q, q.size());
        q = '{8'h80};
        send_message(q, q.size());
        q = '{8'h12, 8'h10, 8'h0A};
        send_message(q, 16'hFFFF);
        q = '{8'h1A, 8'h03, 8'h0A, 8'h01, 8'h7F};
        send_message(q, q.size());
        drain();
    endtask

    task automatic test_random(int snd_pct, int rcv_pct, int n_bytes);
        int stop_at;
        send_idle_pct = snd_pct;
        recv_stall_pct = rcv_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_message();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        repeat (10) send_random_message();
        drain();
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word tdata=%h tuser=%b tlast=%b", $realtime,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.has_value
                    || m_axis_tuser[1] !== want.value_is_integer
                    || m_axis_tdata !== want.value
                    || m_axis_tlast !== want.message_end
                    || m_axis_tuser[2] !== want.stopped_early) begin
                    errors++;
                    $display("%0t: mismatch expected has=%b int=%b val=%h end=%b stop=%b",
                             $realtime, want.has_value, want.value_is_integer, want.value,
                             want.message_end, want.stopped_early);
                    $display("%0t:          actual   has=%b int=%b val=%h end=%b stop=%b",
                             $realtime, m_axis_tuser[0], m_axis_tuser[1],
                             m_axis_tdata, m_axis_tlast, m_axis_tuser[2]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 5000) begin
                $display("protobuf_feature_value_extractor_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        clear_parser();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(0, 0, 300);
        test_random(82, 0, 300);
        test_random(0, 82, 300);
        test_random(7, 7, 300);
        test_backpressure();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("protobuf_feature_value_extractor_test: PASS");
        end else begin
            $display("protobuf_feature_value_extractor_test: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/pfve_pkg.sv
hw/rtl/pfve_parser.sv
hw/rtl/protobuf_feature_value_extractor.sv
hw/rtl/pfve_checker.sv
tb/protobuf_feature_value_extractor_test.sv
